// ----- rtl/topic_filter_wildcard_match_assert.svh -----
// Assertion macros for the topic filter matcher.
// Needs a clock named clk and an active-low reset named arst_n in the including module.
`ifndef TOPIC_FILTER_WILDCARD_MATCH_ASSERT_SVH
`define TOPIC_FILTER_WILDCARD_MATCH_ASSERT_SVH

// Same-cycle implication.
`define TFWM_ASSERT_IMPL(lbl, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) else $error(msg);

// Next-cycle implication.
`define TFWM_ASSERT_NEXT(lbl, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) else $error(msg);

`endif

// ----- rtl/tfwm_pkg.sv -----
// Shared types and character codes for the topic filter matcher.
// No dependencies.
package tfwm_pkg;

	localparam logic [7:0] CHAR_HASH   = 8'h23;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_SLASH  = 8'h2F;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
	} tfwm_head_t;

endpackage

// ----- rtl/tfwm_store.sv -----
// Filter byte memory with load control, length and overflow tracking.
// Depends on tfwm_pkg.
module tfwm_store #(
	parameter int FILTER_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [7:0]                         wr_byte,
	input  logic                               wr_last,
	input  logic                               topic_take,
	input  logic [$clog2(FILTER_DEPTH)-1:0]    rd_addr,
	output logic [7:0]                         rd_data,
	output tfwm_pkg::tfwm_head_t               head,
	output logic [$clog2(FILTER_DEPTH+1)-1:0]  flen,
	output logic                               fovf
);
	import tfwm_pkg::*;

	localparam int LW = $clog2(FILTER_DEPTH + 1);
	localparam int AW = $clog2(FILTER_DEPTH);

	logic [7:0]    mem [FILTER_DEPTH];
	logic [LW-1:0] flen_q;
	logic          fovf_q;
	logic          loading_q;
	logic [LW-1:0] base_len;
	logic          room;

	assign base_len = loading_q ? flen_q : '0;
	assign room     = base_len < LW'(FILTER_DEPTH);
	assign flen     = flen_q;
	assign fovf     = fovf_q;

	always_ff @(posedge clk) begin
		if (wr_en && room) begin
			mem[base_len[AW-1:0]] <= wr_byte;
		end
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en && (base_len == '0)) begin
			head.b0 <= wr_byte;
		end
		if (wr_en && (base_len == LW'(1))) begin
			head.b1 <= wr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q    <= '0;
			fovf_q    <= 1'b0;
			loading_q <= 1'b0;
		end else if (wr_en) begin
			flen_q    <= room ? base_len + LW'(1) : base_len;
			fovf_q    <= (loading_q && fovf_q) || !room;
			loading_q <= !wr_last;
		end else if (topic_take) begin
			loading_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/topic_filter_wildcard_match.sv -----
// Top level of the topic filter matcher: topic byte matching and result buffering.
// Depends on tfwm_pkg, tfwm_store and topic_filter_wildcard_match_assert.svh.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+------------------------------
//   request | req_valid | req_stall | req_type, data_byte, last
//   result  | res_valid | res_stall | matched, filter_error
//
// Filter and topic bytes are taken while req_stall is low; the filter memory is read two positions ahead.
// A topic '/' that meets a run of '+' filter bytes is walked over that run, one memory read per step.
// After reset the filter is empty; the memory needs no clearing pass.
// req_stall is high while such a run is walked or while two result words wait.
`include "topic_filter_wildcard_match_assert.svh"

module topic_filter_wildcard_match #(
	parameter int FILTER_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       req_type,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       matched,
	output logic       filter_error
);
	import tfwm_pkg::*;

	localparam int LW = $clog2(FILTER_DEPTH + 1);
	localparam int AW = $clog2(FILTER_DEPTH);

	typedef enum logic [1:0] {
		PH_COMPARE,
		PH_SKIP,
		PH_HIT,
		PH_MISS
	} phase_t;

	typedef struct packed {
		logic matched;
		logic filter_error;
	} result_t;

	phase_t        phase_q, phase_e, nph;
	logic [LW-1:0] pos_q, pos_e, npos;
	logic [7:0]    c0_q, c1_q, c0_e, c1_e, b_e, c_end;
	logic          c1_fwd_q;
	logic          fresh_q;
	logic          walk_q, walk_last_q;
	logic          take, topic_take, filter_take, run, again, cmp, adv, produce;
	logic          verdict, ferr;
	logic [LW:0]   ra_sum;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	tfwm_head_t    head;
	logic [LW-1:0] flen;
	logic          fovf;
	result_t       res_new, out_q, skid_q;
	logic          out_valid_q, skid_valid_q;

	assign req_stall    = walk_q || skid_valid_q;
	assign take         = req_valid && !req_stall;
	assign topic_take   = take && req_type;
	assign filter_take  = take && !req_type;
	assign run          = topic_take || walk_q;

	assign phase_e = fresh_q ? PH_COMPARE : phase_q;
	assign pos_e   = fresh_q ? '0 : pos_q;
	assign c0_e    = fresh_q ? head.b0 : c0_q;
	assign c1_e    = fresh_q ? head.b1 : (c1_fwd_q ? rd_data : c1_q);
	assign b_e     = walk_q ? CHAR_SLASH : data_byte;

	assign ra_sum  = {1'b0, pos_e} + (LW+1)'(2);
	assign rd_addr = ra_sum[AW-1:0];

	tfwm_store #(
		.FILTER_DEPTH(FILTER_DEPTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (filter_take),
		.wr_byte   (data_byte),
		.wr_last   (last),
		.topic_take(topic_take),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.head      (head),
		.flen      (flen),
		.fovf      (fovf)
	);

	always_comb begin
		nph   = phase_e;
		npos  = pos_e;
		again = 1'b0;
		cmp   = 1'b0;
		if (phase_e == PH_SKIP) begin
			if (b_e == CHAR_SLASH) begin
				nph = PH_COMPARE;
				cmp = 1'b1;
			end
		end else if (phase_e == PH_COMPARE) begin
			cmp = 1'b1;
		end
		if (cmp) begin
			if (pos_e >= flen) begin
				nph = PH_MISS;
			end else if (c0_e == CHAR_HASH) begin
				nph = (b_e == CHAR_DOLLAR) ? PH_MISS : PH_HIT;
			end else if (c0_e == CHAR_PLUS) begin
				if (b_e == CHAR_DOLLAR) begin
					nph = PH_MISS;
				end else begin
					npos = pos_e + LW'(1);
					if (b_e == CHAR_SLASH) begin
						nph   = PH_COMPARE;
						again = 1'b1;
					end else begin
						nph = PH_SKIP;
					end
				end
			end else if (c0_e != b_e) begin
				nph = PH_MISS;
			end else begin
				npos = pos_e + LW'(1);
			end
		end
	end

	assign adv     = run && (npos != pos_e);
	assign c_end   = adv ? c1_e : c0_e;
	assign verdict = (nph == PH_HIT) || (nph == PH_SKIP) ||
		((nph == PH_COMPARE) && ((npos >= flen) || (c_end == CHAR_HASH) ||
		(c_end == CHAR_PLUS)));
	assign ferr    = (flen == '0) || fovf;
	assign res_new = '{matched: verdict && !ferr, filter_error: ferr};
	assign produce = run && !again && (walk_q ? walk_last_q : last);

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_q <= c1_e;
		end else begin
			c0_q <= c0_e;
			c1_q <= c1_e;
		end
		if (run) begin
			pos_q <= npos;
		end else begin
			pos_q <= pos_e;
		end
		if (topic_take) begin
			walk_last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_COMPARE;
			fresh_q  <= 1'b1;
			walk_q   <= 1'b0;
			c1_fwd_q <= 1'b0;
		end else begin
			c1_fwd_q <= adv;
			if (filter_take) begin
				fresh_q <= 1'b1;
			end else if (run) begin
				phase_q <= nph;
				walk_q  <= again;
				fresh_q <= produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !res_stall) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end else if (produce) begin
			skid_q <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !res_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= produce;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	assign res_valid    = out_valid_q;
	assign matched      = out_q.matched;
	assign filter_error = out_q.filter_error;

	`TFWM_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid word without output word")
	`TFWM_ASSERT_IMPL(a_walk_state, walk_q, (phase_q == PH_COMPARE) && !fresh_q, "bad walk state")
	`TFWM_ASSERT_IMPL(a_pos_in_range, !fresh_q, pos_q <= flen, "match position past filter end")
	`TFWM_ASSERT_NEXT(a_walk_starts, run && again, walk_q && req_stall, "plus run walk did not start")
	`TFWM_ASSERT_IMPL(a_result_excl, out_valid_q, !(out_q.matched && out_q.filter_error), "match with error")

endmodule
